### sv/assert_macros.svh
// Shared assertion macros for the table engine checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

### sv/iate_pkg.sv
`default_nettype none
package iate_pkg;

    localparam int DEPTH_DEF = 256;

    localparam logic [3:0] OP_PUSH    = 4'd0;
    localparam logic [3:0] OP_POP     = 4'd1;
    localparam logic [3:0] OP_GET     = 4'd2;
    localparam logic [3:0] OP_SET     = 4'd3;
    localparam logic [3:0] OP_INSERT  = 4'd4;
    localparam logic [3:0] OP_DELETE  = 4'd5;
    localparam logic [3:0] OP_MAX     = 4'd6;
    localparam logic [3:0] OP_MIN     = 4'd7;
    localparam logic [3:0] OP_SUM     = 4'd8;
    localparam logic [3:0] OP_REVERSE = 4'd9;
    localparam logic [3:0] OP_ROTL    = 4'd10;
    localparam logic [3:0] OP_SORTED  = 4'd11;
    localparam logic [3:0] OP_SEARCH  = 4'd12;

    typedef enum logic [2:0] {
        ST_OK, ST_EMPTY, ST_RANGE, ST_FULL, ST_UNSORTED, ST_NOTFOUND
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_RD, S_RDLD, S_INS_CHK, S_INS_WR, S_DEL_CHK, S_DEL_WR,
        S_RED_RD, S_RED_LD, S_RED_CHK, S_RED_OP, S_SR_CHK, S_SR_CMP,
        S_REV_CHK, S_REV_B, S_REV_C, S_REV_D, S_ROT_RD, S_ROT_LD, S_FIN
    } state_t;

    typedef enum logic [2:0] {RS_LO, RS_LOP1, RS_HI, RS_HIM1, RS_MID} rd_sel_t;
    typedef enum logic [1:0] {WA_CNT, WA_POS, WA_LO, WA_HI} wa_sel_t;
    typedef enum logic [1:0] {WD_OPER, WD_RD, WD_TMP} wd_sel_t;
    typedef enum logic [3:0] {
        IX_HOLD, IX_ZERO, IX_POS, IX_CNT, IX_CNTM1, IX_INC, IX_DEC, IX_MIDP1, IX_MIDM1
    } idx_op_t;
    typedef enum logic [1:0] {CN_HOLD, CN_INC, CN_DEC} cnt_op_t;
    typedef enum logic [2:0] {AC_HOLD, AC_LOAD, AC_ADD, AC_MAX, AC_MIN} acc_op_t;

    typedef struct packed {
        logic    take;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        idx_op_t lo_op;
        idx_op_t hi_op;
        cnt_op_t cnt_op;
        acc_op_t acc_op;
        logic    tmp_load;
        logic    sort_set;
        logic    sort_chk;
        logic    out_load;
        status_t out_status;
        logic    res_acc;
        logic    found_mid;
        logic    show_sorted;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic pos_ge_cnt;
        logic pos_gt_cnt;
        logic hi_gt_pos;
        logic lop1_lt_cnt;
        logic lo_lt_cnt;
        logic lo_lt_hi;
        logic lo_le_hi;
        logic key_eq;
        logic key_lt;
        logic sorted;
    } dp_stat_t;

endpackage
`default_nettype wire

### sv/int_array_table_engine.sv
`default_nettype none
// Table of DEPTH signed 32-bit words with a fill count, driven by one opcode
// per input transaction and answering each with exactly one result
// transaction. The entries sit in a single-port memory (one read or one write
// per cycle, read data registered), so the time an operation takes is set by
// how many memory accesses it needs: push, set and error cases at most one
// write, get and pop one read; max, min, sum and the sorted check read every
// entry once; insert and delete read and write each shifted entry; rotate
// reads the first entry, then shifts the others down; reverse reads and
// writes both entries of each swapped pair; search is the sorted check plus
// one read per probe. One operation is in flight at a time; a new transaction
// is accepted as soon as the previous one has moved its result into the
// output register, even if that result still waits for m_ready. Entries never
// written read as anything, but no operation ever reads beyond the fill count.
module int_array_table_engine
    import iate_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_opcode,
    input  wire logic [7:0]         s_position,
    input  wire logic signed [31:0] s_operand_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic signed [31:0]      m_result_value,
    output logic [7:0]              m_found_position,
    output logic                    m_is_sorted,
    output logic [8:0]              m_fill_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each opcode as steps on the datapath
    iate_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the table, indices, accumulator and the result register
    iate_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_position       (s_position),
        .s_operand_value  (s_operand_value),
        .stat             (stat),
        .m_status         (m_status),
        .m_result_value   (m_result_value),
        .m_found_position (m_found_position),
        .m_is_sorted      (m_is_sorted),
        .m_fill_count     (m_fill_count)
    );

endmodule
`default_nettype wire

### sv/iate_dpath.sv
`default_nettype none
module iate_dpath
    import iate_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dp_cmd_t            cmd,
    input  wire logic [7:0]         s_position,
    input  wire logic signed [31:0] s_operand_value,
    output dp_stat_t                stat,
    output logic [2:0]              m_status,
    output logic signed [31:0]      m_result_value,
    output logic [7:0]              m_found_position,
    output logic                    m_is_sorted,
    output logic [8:0]              m_fill_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;
    localparam int XW = ((IW > 9) ? IW : 9) + 1;

    logic signed [31:0] mem [DEPTH];

    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [7:0]         pos_reg;
    logic signed [31:0] val_reg, rd_reg, acc_reg, acc_next, tmp_reg;
    logic               sorted_reg;
    status_t            status_reg;
    logic signed [31:0] result_reg;
    logic [7:0]         found_reg;
    logic               is_sorted_reg;
    logic [8:0]         fill_reg;

    logic signed [XW-1:0] lo_x, hi_x, cnt_x, pos_x, mid_x, sum_x, rdi_x;
    logic [AW-1:0]        ra, wa;
    logic signed [31:0]   wd;

    assign lo_x  = {{(XW-IW){lo_reg[IW-1]}}, lo_reg};
    assign hi_x  = {{(XW-IW){hi_reg[IW-1]}}, hi_reg};
    assign cnt_x = {{(XW-CW){1'b0}}, cnt_reg};
    assign pos_x = {{(XW-8){1'b0}}, pos_reg};
    assign sum_x = lo_x + hi_x;
    assign mid_x = sum_x >>> 1;

    always_comb begin
        stat.cnt_zero    = (cnt_reg == '0);
        stat.cnt_full    = (cnt_reg == CW'(DEPTH));
        stat.pos_ge_cnt  = (pos_x >= cnt_x);
        stat.pos_gt_cnt  = (pos_x > cnt_x);
        stat.hi_gt_pos   = (hi_x > pos_x);
        stat.lop1_lt_cnt = ((lo_x + XW'(1)) < cnt_x);
        stat.lo_lt_cnt   = (lo_x < cnt_x);
        stat.lo_lt_hi    = (lo_x < hi_x);
        stat.lo_le_hi    = (lo_x <= hi_x);
        stat.key_eq      = (val_reg == rd_reg);
        stat.key_lt      = (val_reg < rd_reg);
        stat.sorted      = sorted_reg;
    end

    // Memory read address
    always_comb begin
        case (cmd.rd_sel)
            RS_LO:   rdi_x = lo_x;
            RS_LOP1: rdi_x = lo_x + XW'(1);
            RS_HI:   rdi_x = hi_x;
            RS_HIM1: rdi_x = hi_x - XW'(1);
            RS_MID:  rdi_x = mid_x;
            default: rdi_x = lo_x;
        endcase
        ra = rdi_x[AW-1:0];
    end

    always_comb begin
        case (cmd.wa_sel)
            WA_CNT:  wa = cnt_x[AW-1:0];
            WA_POS:  wa = pos_x[AW-1:0];
            WA_LO:   wa = lo_x[AW-1:0];
            WA_HI:   wa = hi_x[AW-1:0];
            default: wa = lo_x[AW-1:0];
        endcase
        case (cmd.wd_sel)
            WD_OPER: wd = val_reg;
            WD_RD:   wd = rd_reg;
            WD_TMP:  wd = tmp_reg;
            default: wd = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wa] <= wd;
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[ra];
        end
    end

    function automatic logic [IW-1:0] idx_upd(input idx_op_t op,
                                              input logic signed [XW-1:0] cur,
                                              input logic signed [XW-1:0] cnt,
                                              input logic signed [XW-1:0] pos,
                                              input logic signed [XW-1:0] mid);
        logic signed [XW-1:0] v;
        case (op)
            IX_ZERO:  v = '0;
            IX_POS:   v = pos;
            IX_CNT:   v = cnt;
            IX_CNTM1: v = cnt - XW'(1);
            IX_INC:   v = cur + XW'(1);
            IX_DEC:   v = cur - XW'(1);
            IX_MIDP1: v = mid + XW'(1);
            IX_MIDM1: v = mid - XW'(1);
            default:  v = cur;
        endcase
        return v[IW-1:0];
    endfunction

    always_comb begin
        lo_next = idx_upd(cmd.lo_op, lo_x, cnt_x, pos_x, mid_x);
        hi_next = idx_upd(cmd.hi_op, hi_x, cnt_x, pos_x, mid_x);
        case (cmd.cnt_op)
            CN_INC:  cnt_next = cnt_reg + CW'(1);
            CN_DEC:  cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
        case (cmd.acc_op)
            AC_LOAD: acc_next = rd_reg;
            AC_ADD:  acc_next = acc_reg + rd_reg;
            AC_MAX:  acc_next = (rd_reg > acc_reg) ? rd_reg : acc_reg;
            AC_MIN:  acc_next = (rd_reg < acc_reg) ? rd_reg : acc_reg;
            default: acc_next = acc_reg;
        endcase
    end

    // Fill count is control state; everything else is payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        acc_reg <= acc_next;
        if (cmd.take) begin
            pos_reg <= s_position;
            val_reg <= s_operand_value;
        end
        if (cmd.tmp_load) begin
            tmp_reg <= rd_reg;
        end
        if (cmd.sort_set) begin
            sorted_reg <= 1'b1;
        end else if (cmd.sort_chk && (tmp_reg > rd_reg)) begin
            sorted_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            status_reg    <= cmd.out_status;
            result_reg    <= cmd.res_acc ? acc_reg : 32'sd0;
            found_reg     <= cmd.found_mid ? mid_x[7:0] : 8'd0;
            is_sorted_reg <= cmd.show_sorted & sorted_reg;
            fill_reg      <= cnt_x[8:0];
        end
    end

    assign m_status         = status_reg;
    assign m_result_value   = result_reg;
    assign m_found_position = found_reg;
    assign m_is_sorted      = is_sorted_reg;
    assign m_fill_count     = fill_reg;

endmodule
`default_nettype wire

### sv/iate_ctrl.sv
`default_nettype none
module iate_ctrl
    import iate_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [3:0] s_opcode,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd
);

    state_t     state_reg, state_next;
    logic [3:0] op_reg, op_next;
    status_t    st_reg, st_next;
    logic       res_reg, res_next, fnd_reg, fnd_next, shw_reg, shw_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg  <= op_next;
        st_reg  <= st_next;
        res_reg <= res_next;
        fnd_reg <= fnd_next;
        shw_reg <= shw_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        st_next      = st_reg;
        res_next     = res_reg;
        fnd_next     = fnd_reg;
        shw_next     = shw_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    op_next    = s_opcode;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                st_next    = ST_OK;
                res_next   = 1'b0;
                fnd_next   = 1'b0;
                shw_next   = 1'b0;
                state_next = S_FIN;
                case (op_reg)
                    OP_PUSH: begin
                        if (stat.cnt_full) begin
                            st_next = ST_FULL;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_CNT;
                            cmd.wd_sel = WD_OPER;
                            cmd.cnt_op = CN_INC;
                        end
                    end
                    OP_POP: begin
                        if (stat.cnt_zero) begin
                            st_next = ST_EMPTY;
                        end else begin
                            cmd.cnt_op = CN_DEC;
                            cmd.lo_op  = IX_CNTM1;
                            state_next = S_RD;
                        end
                    end
                    OP_GET: begin
                        if (stat.cnt_zero) begin
                            st_next = ST_EMPTY;
                        end else if (stat.pos_ge_cnt) begin
                            st_next = ST_RANGE;
                        end else begin
                            cmd.lo_op  = IX_POS;
                            state_next = S_RD;
                        end
                    end
                    OP_SET: begin
                        if (stat.pos_ge_cnt) begin
                            st_next = ST_RANGE;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_POS;
                            cmd.wd_sel = WD_OPER;
                        end
                    end
                    OP_INSERT: begin
                        if (stat.pos_gt_cnt) begin
                            st_next = ST_RANGE;
                        end else if (stat.cnt_full) begin
                            st_next = ST_FULL;
                        end else begin
                            cmd.hi_op  = IX_CNT;
                            state_next = S_INS_CHK;
                        end
                    end
                    OP_DELETE: begin
                        if (stat.pos_ge_cnt) begin
                            st_next = ST_RANGE;
                        end else begin
                            cmd.lo_op  = IX_POS;
                            state_next = S_DEL_CHK;
                        end
                    end
                    OP_MAX, OP_MIN, OP_SUM, OP_SORTED, OP_SEARCH: begin
                        if (stat.cnt_zero) begin
                            st_next = ST_EMPTY;
                        end else begin
                            cmd.lo_op    = IX_ZERO;
                            cmd.sort_set = 1'b1;
                            state_next   = S_RED_RD;
                        end
                    end
                    OP_REVERSE: begin
                        if (stat.cnt_zero) begin
                            st_next = ST_EMPTY;
                        end else begin
                            cmd.lo_op  = IX_ZERO;
                            cmd.hi_op  = IX_CNTM1;
                            state_next = S_REV_CHK;
                        end
                    end
                    OP_ROTL: begin
                        if (stat.cnt_zero) begin
                            st_next = ST_EMPTY;
                        end else begin
                            cmd.lo_op  = IX_ZERO;
                            state_next = S_ROT_RD;
                        end
                    end
                    default: begin
                        st_next = ST_OK;
                    end
                endcase
            end
            S_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RS_LO;
                state_next = S_RDLD;
            end
            S_RDLD: begin
                cmd.acc_op = AC_LOAD;
                res_next   = 1'b1;
                state_next = S_FIN;
            end
            S_INS_CHK: begin
                if (stat.hi_gt_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_HIM1;
                    state_next = S_INS_WR;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_POS;
                    cmd.wd_sel = WD_OPER;
                    cmd.cnt_op = CN_INC;
                    state_next = S_FIN;
                end
            end
            S_INS_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_HI;
                cmd.wd_sel = WD_RD;
                cmd.hi_op  = IX_DEC;
                state_next = S_INS_CHK;
            end
            S_DEL_CHK: begin
                if (stat.lop1_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_LOP1;
                    state_next = S_DEL_WR;
                end else begin
                    if (op_reg == OP_ROTL) begin
                        cmd.wr_en  = 1'b1;
                        cmd.wa_sel = WA_LO;
                        cmd.wd_sel = WD_TMP;
                    end else begin
                        cmd.cnt_op = CN_DEC;
                    end
                    state_next = S_FIN;
                end
            end
            S_DEL_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_LO;
                cmd.wd_sel = WD_RD;
                cmd.lo_op  = IX_INC;
                state_next = S_DEL_CHK;
            end
            S_RED_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RS_LO;
                cmd.lo_op  = IX_INC;
                state_next = S_RED_LD;
            end
            S_RED_LD: begin
                cmd.acc_op   = AC_LOAD;
                cmd.tmp_load = 1'b1;
                state_next   = S_RED_CHK;
            end
            S_RED_CHK: begin
                if (stat.lo_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_LO;
                    cmd.lo_op  = IX_INC;
                    state_next = S_RED_OP;
                end else begin
                    state_next = S_FIN;
                    if (op_reg == OP_SORTED) begin
                        shw_next = 1'b1;
                    end else if (op_reg == OP_SEARCH) begin
                        shw_next = 1'b1;
                        if (stat.sorted) begin
                            cmd.lo_op  = IX_ZERO;
                            cmd.hi_op  = IX_CNTM1;
                            state_next = S_SR_CHK;
                        end else begin
                            st_next = ST_UNSORTED;
                        end
                    end else begin
                        res_next = 1'b1;
                    end
                end
            end
            S_RED_OP: begin
                case (op_reg)
                    OP_MAX:  cmd.acc_op = AC_MAX;
                    OP_MIN:  cmd.acc_op = AC_MIN;
                    OP_SUM:  cmd.acc_op = AC_ADD;
                    default: cmd.acc_op = AC_HOLD;
                endcase
                cmd.tmp_load = 1'b1;
                cmd.sort_chk = 1'b1;
                state_next   = S_RED_CHK;
            end
            S_SR_CHK: begin
                if (stat.lo_le_hi) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_MID;
                    state_next = S_SR_CMP;
                end else begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_FIN;
                end
            end
            S_SR_CMP: begin
                if (stat.key_eq) begin
                    fnd_next   = 1'b1;
                    state_next = S_FIN;
                end else begin
                    if (stat.key_lt) begin
                        cmd.hi_op = IX_MIDM1;
                    end else begin
                        cmd.lo_op = IX_MIDP1;
                    end
                    state_next = S_SR_CHK;
                end
            end
            S_REV_CHK: begin
                if (stat.lo_lt_hi) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_LO;
                    state_next = S_REV_B;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_REV_B: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RS_HI;
                cmd.tmp_load = 1'b1;
                state_next   = S_REV_C;
            end
            S_REV_C: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_LO;
                cmd.wd_sel = WD_RD;
                state_next = S_REV_D;
            end
            S_REV_D: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_HI;
                cmd.wd_sel = WD_TMP;
                cmd.lo_op  = IX_INC;
                cmd.hi_op  = IX_DEC;
                state_next = S_REV_CHK;
            end
            S_ROT_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RS_LO;
                state_next = S_ROT_LD;
            end
            S_ROT_LD: begin
                cmd.tmp_load = 1'b1;
                state_next   = S_DEL_CHK;
            end
            S_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = st_reg;
                    cmd.res_acc     = res_reg;
                    cmd.found_mid   = fnd_reg;
                    cmd.show_sorted = shw_reg;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

### sv/iate_checker.sv
`default_nettype none
`include "assert_macros.svh"
module iate_checker
    import iate_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [3:0]         s_opcode,
    input wire logic [7:0]         s_position,
    input wire logic signed [31:0] s_operand_value,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [2:0]         m_status,
    input wire logic signed [31:0] m_result_value,
    input wire logic [7:0]         m_found_position,
    input wire logic               m_is_sorted,
    input wire logic [8:0]         m_fill_count
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_result_value) && $stable(m_fill_count)), "result transaction changed while stalled")
    `ASSERT_IMPL(a_err_zero, aclk, aresetn, m_valid && (m_status != ST_OK), m_result_value == 32'sd0, "error result carries a value")
    `ASSERT_IMPL(a_full_cnt, aclk, aresetn, m_valid && (m_status == ST_FULL), m_fill_count == 9'(DEPTH), "full reported below capacity")
    `ASSERT_IMPL(a_unsorted, aclk, aresetn, m_valid && (m_status == ST_UNSORTED), !m_is_sorted, "not sorted reported with sorted flag")

endmodule

bind int_array_table_engine iate_checker #(.DEPTH(DEPTH)) u_iate_checker (.*);
`default_nettype wire
